// ----- src/pcmr_pkg.sv -----
package pcmr_pkg;

   localparam int IN_CHANNELS = 256;
   localparam int OUT_LANES   = 16;

   localparam int CH_W   = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

   localparam int ACT_W  = 13;
   localparam int ACC_W  = 32;
   localparam int CSR_IW = 2;

   typedef enum logic [1:0] {
      ACT_ACTIVATION = 2'd0,
      ACT_WEIGHT     = 2'd1,
      ACT_BIAS       = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_SPATIAL   = 2'd0,
      KIND_POINTWISE = 2'd1,
      KIND_RESIDUAL  = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_LAYER_KIND = 2'd0,
      CSR_ACTIVE     = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         channel;
      logic [3:0]         out_channel;
      logic signed [15:0] value;
      logic               pixel_end;
   } req_type;

   typedef struct packed {
      logic [3:0]         result_channel;
      logic signed [31:0] result_value;
      logic               result_last;
   } rsp_type;

   typedef logic [OUT_LANES-1:0][7:0]      weight_row_type;
   typedef logic [OUT_LANES-1:0][ACC_W-1:0] acc_row_type;

   // weight memory access, at most one per accepted item
   typedef struct packed {
      logic              wr;
      logic              rd;
      logic [CH_W-1:0]   addr;
      logic [LANE_W-1:0] lane;
      logic [7:0]        data;
   } mem_req_type;

   typedef struct packed {
      logic               load;
      logic signed [7:0]  act;
      logic [7:0]         channel;
      logic               use_ch;
      logic               pixel_end;
   } elem_type;

   typedef struct packed {
      logic               en;
      logic [LANE_W-1:0]  lane;
      logic signed [15:0] bias;
   } bias_wr_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ACT_W-1:0] active;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic adv;
   } mac_stat_type;

   typedef struct packed {
      logic           load;
      logic           ok;
      acc_row_type    acc;
      weight_row_type res;
   } out_load_type;

endpackage

// ----- src/pointwise_conv_mac_residual.sv -----
// channel  direction  ports                         moves
// req      in         req_valid req_ready req_data  one action item per transfer
// rsp      out        rsp_valid rsp_ready rsp_data  one output channel result per transfer
// csr      in         csr_valid csr_ready csr_index csr_data  one register write per transfer
//
// req takes one item per cycle; an activation's weight row is read out of the
// weight memory in the next cycle and is accumulated in all sixteen lanes in that cycle
// a pixel_end drains sixteen results from the output buffer, one per cycle
// while rsp_ready is high; req stalls only when a pixel_end reaches the mac
// stage while the previous pixel's results are still draining
// reset is synchronous; weights and biases hold no reset value and must be
// written before use, csr_ready is always high
module pointwise_conv_mac_residual (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pcmr_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pcmr_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pcmr_pkg::CSR_IW-1:0]   csr_index,
   input  logic [pcmr_pkg::ACT_W-1:0]    csr_data
);
   import pcmr_pkg::*;

   logic [1:0]       kind_ff;
   logic [ACT_W-1:0] active_ff;
   logic             req_xfer;
   logic             is_act;
   mem_req_type      mem_req;
   weight_row_type   w_row;
   elem_type         elem;
   bias_wr_type      bias_wr;
   cfg_type          cfg;
   mac_stat_type     mac_stat;
   out_load_type     out_load;
   logic             out_free;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_NONE;
         active_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LAYER_KIND: kind_ff   <= csr_data[1:0];
            CSR_ACTIVE:     active_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   assign cfg.kind   = kind_ff;
   assign cfg.active = active_ff;

   // the mac stage must be empty or moving on for a new item to enter
   assign req_ready = !mac_stat.valid || mac_stat.adv;
   assign req_xfer  = req_valid && req_ready;
   assign is_act    = (req_data.action == ACT_ACTIVATION);

   // weight writes land directly; activations read their weight row
   always_comb begin
      mem_req.wr   = req_xfer && (req_data.action == ACT_WEIGHT)
                     && (int'(req_data.channel) < IN_CHANNELS)
                     && (int'(req_data.out_channel) < OUT_LANES);
      mem_req.rd   = req_xfer && is_act;
      mem_req.addr = CH_W'(req_data.channel);
      mem_req.lane = LANE_W'(req_data.out_channel);
      mem_req.data = req_data.value[7:0];
   end

   // bias writes go straight to the lane registers
   always_comb begin
      bias_wr.en   = req_xfer && (req_data.action == ACT_BIAS)
                     && (int'(req_data.out_channel) < OUT_LANES);
      bias_wr.lane = LANE_W'(req_data.out_channel);
      bias_wr.bias = req_data.value;
   end

   // channel gating uses the active count at arrival
   always_comb begin
      elem.load      = req_xfer && is_act;
      elem.act       = $signed(req_data.value[7:0]);
      elem.channel   = req_data.channel;
      elem.use_ch    = (ACT_W'(req_data.channel) < active_ff)
                       && (int'(req_data.channel) < IN_CHANNELS);
      elem.pixel_end = req_data.pixel_end;
   end

   pcmr_weight_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_row  (w_row)
   );

   pcmr_mac_lanes u_mac (
      .clock    (clock),
      .reset    (reset),
      .elem     (elem),
      .bias_wr  (bias_wr),
      .cfg      (cfg),
      .w_row    (w_row),
      .out_free (out_free),
      .stat     (mac_stat),
      .out_load (out_load)
   );

   pcmr_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .out_load  (out_load),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a held mac stage only waits on a busy output buffer
   assert property (@(posedge clock) disable iff (reset)
      (mac_stat.valid && !mac_stat.adv) |-> (rsp_valid && mac_stat.valid))
      else $error("mac stage stalled without pending results");

   // results are loaded only into a free buffer
   assert property (@(posedge clock) disable iff (reset)
      out_load.load |-> out_free)
      else $error("output buffer overwritten while draining");

   // a pixel's results run without a gap in valid until the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.result_last) |=> rsp_valid)
      else $error("result burst cut short");

   // no new item enters while the mac stage holds
   assert property (@(posedge clock) disable iff (reset)
      (mac_stat.valid && !mac_stat.adv) |-> !req_ready)
      else $error("item accepted over a held mac stage");

endmodule

// ----- src/pcmr_weight_mem.sv -----
module pcmr_weight_mem (
   input  logic                    clock,
   input  pcmr_pkg::mem_req_type   mem_req,
   output pcmr_pkg::weight_row_type rd_row
);
   import pcmr_pkg::*;

   // one row per input channel, one byte lane per output channel
   weight_row_type mem_ff [IN_CHANNELS];
   weight_row_type rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr) begin
         mem_ff[mem_req.addr][mem_req.lane] <= mem_req.data;
      end
      if (mem_req.rd) begin
         rd_ff <= mem_ff[mem_req.addr];
      end
   end

   assign rd_row = rd_ff;

endmodule

// ----- src/pcmr_mac_lanes.sv -----
module pcmr_mac_lanes (
   input  logic                     clock,
   input  logic                     reset,
   input  pcmr_pkg::elem_type       elem,
   input  pcmr_pkg::bias_wr_type    bias_wr,
   input  pcmr_pkg::cfg_type        cfg,
   input  pcmr_pkg::weight_row_type w_row,
   input  logic                     out_free,
   output pcmr_pkg::mac_stat_type   stat,
   output pcmr_pkg::out_load_type   out_load
);
   import pcmr_pkg::*;

   logic                      s1_valid_ff;
   elem_type                  s1_ff;
   logic                      open_ff;
   acc_row_type               acc_ff;
   acc_row_type               acc_in;
   weight_row_type            res_ff;
   weight_row_type            res_in;
   logic signed [15:0]        bias_ff [OUT_LANES];
   logic signed [15:0]        prod [OUT_LANES];
   logic signed [ACC_W-1:0]   base [OUT_LANES];
   logic                      adv;
   logic                      ok;
   logic                      resid;

   assign adv = s1_valid_ff && (!s1_ff.pixel_end || out_free);
   assign ok = (cfg.active != '0) && (int'(cfg.active) <= IN_CHANNELS)
               && (cfg.kind != KIND_NONE);
   assign resid = (cfg.kind == KIND_RESIDUAL);

   // sixteen lanes of multiply and accumulate
   always_comb begin
      for (int k = 0; k < OUT_LANES; k++) begin
         prod[k] = s1_ff.act * $signed(w_row[k]);
         base[k] = open_ff ? $signed(acc_ff[k]) : ACC_W'(bias_ff[k]);
         acc_in[k] = s1_ff.use_ch ? ACC_W'(base[k] + ACC_W'(prod[k])) : base[k];
         if (s1_ff.use_ch && int'(s1_ff.channel) == k) begin
            res_in[k] = s1_ff.act;
         end else begin
            res_in[k] = open_ff ? res_ff[k] : 8'd0;
         end
      end
   end

   always_comb begin
      out_load.load = adv && s1_ff.pixel_end;
      out_load.ok   = ok;
      out_load.acc  = acc_in;
      for (int k = 0; k < OUT_LANES; k++) begin
         out_load.res[k] = (ok && resid && k < int'(cfg.active)) ? res_in[k] : 8'd0;
      end
   end

   assign stat.valid = s1_valid_ff;
   assign stat.adv   = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (elem.load) begin
         s1_valid_ff <= 1'b1;
      end else if (adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (elem.load) begin
         s1_ff <= elem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         acc_ff  <= '0;
         res_ff  <= '0;
      end else if (adv) begin
         open_ff <= !s1_ff.pixel_end;
         acc_ff  <= acc_in;
         res_ff  <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < OUT_LANES; k++) begin
         if (bias_wr.en && int'(bias_wr.lane) == k) begin
            bias_ff[k] <= bias_wr.bias;
         end
      end
   end

endmodule

// ----- src/pcmr_out_buf.sv -----
module pcmr_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  pcmr_pkg::out_load_type out_load,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pcmr_pkg::rsp_type      rsp_data
);
   import pcmr_pkg::*;

   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(OUT_LANES - 1);

   logic              busy_ff;
   logic [LANE_W-1:0] idx_ff;
   logic              ok_ff;
   acc_row_type       acc_ff;
   weight_row_type    res_ff;
   logic              done;

   assign done     = busy_ff && rsp_ready && (idx_ff == LAST_LANE);
   assign out_free = !busy_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (out_load.load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         busy_ff <= !done;
         idx_ff  <= done ? '0 : LANE_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load.load) begin
         ok_ff  <= out_load.ok;
         acc_ff <= out_load.acc;
         res_ff <= out_load.res;
      end
   end

   assign rsp_valid               = busy_ff;
   assign rsp_data.result_channel = 4'(idx_ff);
   assign rsp_data.result_value   = ok_ff ?
      ACC_W'($signed(acc_ff[idx_ff]) + ACC_W'($signed(res_ff[idx_ff]))) : '0;
   assign rsp_data.result_last    = (idx_ff == LAST_LANE);

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pcmr_pkg::*;

   // run length guard and the settle time after the last transfer
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PIPE_SETTLE  = 10;
   localparam int N_PHASES     = 11;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, driven only by the driver block
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;

   // result side, ready driven only by the monitor block
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // register write port, driven only by the stimulus process
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [ACT_W-1:0]  csr_data  = '0;

   // items waiting to be offered, and per-lane results owed by the block
   req_type req_backlog [$];
   rsp_type lane_results_due [$];

   // stall rates in percent, changed only at a falling edge
   int send_idle_pct = 25;
   int recv_idle_pct = 46;

   // bookkeeping
   int cycle_count     = 0;
   int error_count     = 0;
   int items_accepted  = 0;
   int pixels_closed   = 0;
   int results_checked = 0;

   // predictor copy of the configuration, reset values
   kind_type         cfg_kind   = KIND_NONE;
   logic [ACT_W-1:0] cfg_active = '0;

   // predictor copy of the stores
   logic signed [7:0]  wt_mem    [OUT_LANES][IN_CHANNELS];
   logic signed [15:0] bias_mem  [OUT_LANES];
   logic        [31:0] acc_mem   [OUT_LANES] = '{default: '0};
   logic signed [7:0]  resid_mem [OUT_LANES] = '{default: '0};
   bit                 px_open = 1'b0;

   // which weight lanes of each input channel the stimulus has written so far
   logic [OUT_LANES-1:0] col_written [IN_CHANNELS] = '{default: '0};

   // configuration per random phase; the last active count is drawn at run time
   kind_type phase_kind [N_PHASES] = '{KIND_POINTWISE, KIND_SPATIAL, KIND_RESIDUAL,
                                       KIND_RESIDUAL, KIND_NONE, KIND_POINTWISE,
                                       KIND_RESIDUAL, KIND_POINTWISE, KIND_SPATIAL,
                                       KIND_RESIDUAL, KIND_POINTWISE};
   int phase_active [N_PHASES] = '{8, 3, 16, 18, 5, 0, 256, 257, 4096, 1, 0};

   rsp_type want_r;

   pointwise_conv_mac_residual DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // predictor: one accepted request in, zero or sixteen lane results out
   // -------------------------------------------------------------------------
   function automatic void mac_predict(req_type it);
      logic signed [7:0] act_b;
      logic [31:0]       r;
      bit                ok;
      rsp_type           res;
      act_b = it.value[7:0];
      case (action_type'(it.action))
         ACT_WEIGHT: wt_mem[it.out_channel][it.channel] = act_b;
         ACT_BIAS:   bias_mem[it.out_channel] = it.value;
         ACT_ACTIVATION: begin
            // first element of a pixel loads the biases and clears the residual copy
            if (!px_open) begin
               for (int k = 0; k < OUT_LANES; k++) begin
                  acc_mem[k]   = 32'(int'(bias_mem[k]));
                  resid_mem[k] = '0;
               end
               px_open = 1'b1;
            end
            // channels at or above the active count add nothing
            if (it.channel < cfg_active) begin
               for (int k = 0; k < OUT_LANES; k++)
                  acc_mem[k] = acc_mem[k] + 32'(int'(act_b) * int'(wt_mem[k][it.channel]));
               if (it.channel < OUT_LANES)
                  resid_mem[it.channel[LANE_W-1:0]] = act_b;
            end
            if (it.pixel_end) begin
               // validity and residual mode are judged here, at the end of the pixel
               ok = (cfg_active >= 1) && (cfg_active <= IN_CHANNELS) && (cfg_kind != KIND_NONE);
               for (int k = 0; k < OUT_LANES; k++) begin
                  r = '0;
                  if (ok) begin
                     r = acc_mem[k];
                     if (cfg_kind == KIND_RESIDUAL && k < cfg_active)
                        r = r + 32'(int'(resid_mem[k]));
                  end
                  res.result_channel = 4'(k);
                  res.result_value   = r;
                  res.result_last    = (k == OUT_LANES - 1);
                  lane_results_due.push_back(res);
               end
               px_open = 1'b0;
               pixels_closed++;
            end
         end
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // stimulus helpers; the functions are called in zero time at a falling edge
   // -------------------------------------------------------------------------
   function automatic void queue_item(action_type act, int ch, int lane,
                                      logic [15:0] val, bit last);
      req_type it;
      it.action      = act;
      it.channel     = 8'(ch);
      it.out_channel = 4'(lane);
      it.value       = val;
      it.pixel_end   = last;
      if (act == ACT_WEIGHT)
         col_written[ch][lane] = 1'b1;
      req_backlog.push_back(it);
   endfunction

   // every lane of a channel gets a weight before any activation reads it
   function automatic void ensure_column(int ch);
      for (int lane = 0; lane < OUT_LANES; lane++)
         if (!col_written[ch][lane])
            queue_item(ACT_WEIGHT, ch, lane, 16'($urandom), 1'($urandom_range(1)));
   endfunction

   // mostly channels in use, some ignored ones above the active count
   function automatic int pick_channel();
      int lim;
      int ch;
      lim = (cfg_active > IN_CHANNELS) ? IN_CHANNELS : int'(cfg_active);
      if (lim == 0)
         return $urandom_range(IN_CHANNELS - 1);
      if (lim < IN_CHANNELS && $urandom_range(9) < 2)
         return $urandom_range(IN_CHANNELS - 1, lim);
      if (lim <= 4)
         ch = $urandom_range(lim - 1);
      else if ($urandom_range(1))
         ch = $urandom_range(3);
      else
         ch = lim - 1;
      ensure_column(ch);
      return ch;
   endfunction

   // noise between elements: stray weight, bias or no-op items
   function automatic void gen_side_item();
      case ($urandom_range(2))
         0: queue_item(ACT_WEIGHT, $urandom_range(255), $urandom_range(15),
                       16'($urandom), 1'($urandom_range(1)));
         1: queue_item(ACT_BIAS, $urandom_range(255), $urandom_range(15),
                       16'($urandom), 1'($urandom_range(1)));
         default: queue_item(ACT_NONE, $urandom_range(255), $urandom_range(15),
                             16'($urandom), 1'($urandom_range(1)));
      endcase
   endfunction

   function automatic void gen_pixel(bit keep_open);
      int n;
      int ch;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 18)
            gen_side_item();
         ch = pick_channel();
         queue_item(ACT_ACTIVATION, ch, $urandom_range(15), 16'($urandom),
                    (i == n - 1) && !keep_open);
      end
   endfunction

   // register write, predictor copy updated at the accepting edge
   task automatic write_csr(csr_index_type idx, logic [ACT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LAYER_KIND)
         cfg_kind = kind_type'(data[1:0]);
      else
         cfg_active = data;
   endtask

   // everything offered, accepted and answered, then a settle time for the pipe
   task automatic drain_pipeline();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || lane_results_due.size() != 0);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // driver: offers backlog items, predicts each transfer as it happens
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            mac_predict(req_data);
            items_accepted++;
         end
         // payload may change only when nothing is held or it just went through
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // monitor: random back-pressure, in-order compare of every result transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (lane_results_due.size() == 0) begin
               $error("unexpected result: result_channel %0d result_value %0d result_last %0d",
                      rsp_data.result_channel, rsp_data.result_value, rsp_data.result_last);
               error_count++;
            end else begin
               want_r = lane_results_due.pop_front();
               if (rsp_data.result_channel !== want_r.result_channel) begin
                  $error("result_channel expected %0d actual %0d",
                         want_r.result_channel, rsp_data.result_channel);
                  error_count++;
               end
               if (rsp_data.result_value !== want_r.result_value) begin
                  $error("result_value expected %0d actual %0d (lane %0d)",
                         want_r.result_value, rsp_data.result_value, want_r.result_channel);
                  error_count++;
               end
               if (rsp_data.result_last !== want_r.result_last) begin
                  $error("result_last expected %0d actual %0d (lane %0d)",
                         want_r.result_last, rsp_data.result_last, want_r.result_channel);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pointwise_conv_mac_residual: mismatch");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // stimulus sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [15:0] bias_v;
      int          npx;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part runs in residual mode over four channels
      write_csr(CSR_LAYER_KIND, ACT_W'(KIND_RESIDUAL));
      write_csr(CSR_ACTIVE, 13'd4);
      @(negedge clock);

      // all biases first, extremes on the low lanes; the mark on a write is ignored
      for (int lane = 0; lane < OUT_LANES; lane++) begin
         case (lane)
            0:       bias_v = 16'h8000;
            1:       bias_v = 16'h7fff;
            2:       bias_v = 16'h0000;
            3:       bias_v = 16'hffff;
            default: bias_v = 16'($urandom);
         endcase
         queue_item(ACT_BIAS, $urandom_range(255), lane, bias_v, 1'(lane));
      end
      for (int ch = 0; ch < 4; ch++)
         ensure_column(ch);
      // weight extremes, upper byte of value must be dropped
      queue_item(ACT_WEIGHT, 0, 0, 16'h0080, 1'b1);
      queue_item(ACT_WEIGHT, 1, 0, 16'hff7f, 1'b0);
      // no-op item carrying a mark gives nothing
      queue_item(ACT_NONE, 255, 15, 16'hffff, 1'b1);
      // activation extremes, a repeated channel and an ignored one
      queue_item(ACT_ACTIVATION, 0, 0, 16'hff80, 1'b0);
      queue_item(ACT_ACTIVATION, 1, 15, 16'h007f, 1'b0);
      queue_item(ACT_ACTIVATION, 0, 0, 16'h0005, 1'b0);
      queue_item(ACT_ACTIVATION, 200, 0, 16'h7fff, 1'b0);
      queue_item(ACT_ACTIVATION, 3, 0, 16'h8001, 1'b1);
      // bias written inside an open pixel only shows up on the next pixel
      queue_item(ACT_ACTIVATION, 2, 0, 16'($urandom), 1'b0);
      queue_item(ACT_BIAS, 0, 0, 16'd123, 1'b0);
      queue_item(ACT_ACTIVATION, 1, 0, 16'($urandom), 1'b1);
      queue_item(ACT_ACTIVATION, 0, 0, 16'($urandom), 1'b1);
      // weight written between two elements of one pixel hits the second
      queue_item(ACT_ACTIVATION, 0, 0, 16'h0011, 1'b0);
      queue_item(ACT_WEIGHT, 0, 3, 16'h0080, 1'b0);
      queue_item(ACT_ACTIVATION, 0, 0, 16'h0011, 1'b1);
      // pixel made of an ignored channel only
      queue_item(ACT_ACTIVATION, 255, 0, 16'($urandom), 1'b1);

      // random phases; two of them leave a pixel open across the register change
      for (int p = 0; p < N_PHASES; p++) begin
         drain_pipeline();
         if (p == 4) begin
            send_idle_pct = 46;
            recv_idle_pct = 25;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_LAYER_KIND, ACT_W'(phase_kind[p]));
         write_csr(CSR_ACTIVE, (p == N_PHASES - 1) ? 13'($urandom_range(1, 24))
                                                  : 13'(phase_active[p]));
         @(negedge clock);
         npx = $urandom_range(2, 4);
         for (int x = 0; x < npx; x++)
            gen_pixel((x == npx - 1) && (p == 2 || p == 9));
      end
      drain_pipeline();

      $display("%0d request transfers, %0d pixels closed, %0d result transfers compared",
               items_accepted, pixels_closed, results_checked);
      $display("all layer kinds, active counts from 0 to 4096, stalls on either side then none");
      if (error_count == 0)
         $display("pointwise_conv_mac_residual: match");
      else
         $display("pointwise_conv_mac_residual: mismatch");
      $finish;
   end

endmodule
